// ===== src/sbd_pkg.sv =====
// Shared types, constants and helper functions of the supersample box downscaler.
package sbd_pkg;

  localparam int MAX_LOGICAL_WIDTH  = 1024;
  localparam int MAX_LOGICAL_HEIGHT = 1024;
  localparam int MAX_FACTOR         = 4;
  localparam int CHANNELS           = 4;

  localparam int DIM_W    = 11;                          // config width of a dimension
  localparam int COL_W    = $clog2(MAX_LOGICAL_WIDTH);   // logical column counter
  localparam int ROW_W    = $clog2(MAX_LOGICAL_HEIGHT);  // logical row counter
  localparam int FACTOR_W = 3;                           // config width of the factor
  localparam int SAMP_W   = $clog2(MAX_FACTOR);          // sample row/column counter
  localparam int SUM_W    = 12;                          // holds 16 * 255
  localparam int CFG_W    = 11;                          // widest register
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR   = 2'd2;

  // Reciprocal of nine in 16 fractional bits; exact for every block sum of factor three
  localparam logic [25:0] RECIP_NINE = 26'd7282;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_last;
  } pixel_out_t;

  // Controller to datapath
  typedef struct packed {
    logic              capture;     // latch the item and read its column sums
    logic              write_back;  // store the updated column sums
    logic              load_out;    // load the block mean into the output register
    logic [COL_W-1:0]  col;         // column of the captured item
    logic              first;       // first sample of its block
    logic              frame_last;  // block is the frame's last logical pixel
    logic [SAMP_W-1:0] factor_m1;   // effective factor minus one
  } sbd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;                 // a result waits and is not taken this cycle
  } sbd_status_t;

  // Effective dimension minus one: zero reads as one, above maximum saturates.
  function automatic logic [COL_W-1:0] dim_m1(input logic [DIM_W-1:0] raw,
                                              input int unsigned max_dim);
    logic [DIM_W-1:0] lim;
    logic [DIM_W-1:0] d;
    lim = DIM_W'(max_dim);
    d   = raw;
    if (raw == '0) begin
      d = DIM_W'(1);
    end else if (raw > lim) begin
      d = lim;
    end
    return COL_W'(d - DIM_W'(1));
  endfunction

  function automatic logic [SAMP_W-1:0] factor_m1(input logic [FACTOR_W-1:0] raw);
    logic [FACTOR_W-1:0] f;
    f = raw;
    if (raw == '0) begin
      f = FACTOR_W'(1);
    end else if (raw > FACTOR_W'(MAX_FACTOR)) begin
      f = FACTOR_W'(MAX_FACTOR);
    end
    return SAMP_W'(f - FACTOR_W'(1));
  endfunction

  // Rounded mean of a block sum over factor squared samples.
  function automatic logic [7:0] block_mean(input logic [SUM_W-1:0] s,
                                            input logic [SAMP_W-1:0] fm1);
    logic [SUM_W:0] r;
    logic [25:0]    p;
    logic [7:0]     m;
    r = '0;
    p = '0;
    m = '0;
    case (fm1)
      2'd0: m = s[7:0];
      2'd1: begin
        r = {1'b0, s} + (SUM_W+1)'(2);
        m = r[9:2];
      end
      2'd2: begin
        r = {1'b0, s} + (SUM_W+1)'(4);
        p = 26'(r) * RECIP_NINE;
        m = p[23:16];
      end
      default: begin
        r = {1'b0, s} + (SUM_W+1)'(8);
        m = r[11:4];
      end
    endcase
    return m;
  endfunction

endpackage

// ===== src/sbd_ctrl.sv =====
// Controller: configuration registers, raster position counters and sequencing FSM.
module sbd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sbd_pkg::sbd_status_t          status,
  output sbd_pkg::sbd_cmd_t             cmd
);
  import sbd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;

  logic [1:0]          state, state_next;
  logic [DIM_W-1:0]    width_raw, height_raw;
  logic [FACTOR_W-1:0] factor_raw;
  logic [COL_W-1:0]    wm1;
  logic [ROW_W-1:0]    hm1;
  logic [SAMP_W-1:0]   fm1;
  logic [COL_W-1:0]    lcol, lcol_next;
  logic [ROW_W-1:0]    lrow, lrow_next;
  logic [SAMP_W-1:0]   scol, scol_next, srow, srow_next;
  logic                last_q;
  logic                accept, last_now, restart;

  assign wm1 = dim_m1(width_raw, MAX_LOGICAL_WIDTH);
  assign hm1 = ROW_W'(dim_m1(height_raw, MAX_LOGICAL_HEIGHT));
  assign fm1 = factor_m1(factor_raw);

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign last_now = (srow == fm1) && (scol == fm1);
  assign restart  = cfg_we && (cfg_index == CFG_LOGICAL_WIDTH ||
                               cfg_index == CFG_LOGICAL_HEIGHT ||
                               cfg_index == CFG_SCALE_FACTOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_raw  <= DIM_W'(1);
      height_raw <= DIM_W'(1);
      factor_raw <= FACTOR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOGICAL_WIDTH:  width_raw  <= cfg_data[DIM_W-1:0];
        CFG_LOGICAL_HEIGHT: height_raw <= cfg_data[DIM_W-1:0];
        CFG_SCALE_FACTOR:   factor_raw <= cfg_data[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Raster walk: sample column, logical column, sample row, logical row.
  always_comb begin
    scol_next = scol;
    lcol_next = lcol;
    srow_next = srow;
    lrow_next = lrow;
    if (scol == fm1) begin
      scol_next = '0;
      if (lcol == wm1) begin
        lcol_next = '0;
        if (srow == fm1) begin
          srow_next = '0;
          lrow_next = (lrow == hm1) ? '0 : lrow + ROW_W'(1);
        end else begin
          srow_next = srow + SAMP_W'(1);
        end
      end else begin
        lcol_next = lcol + COL_W'(1);
      end
    end else begin
      scol_next = scol + SAMP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      scol <= '0;
      lcol <= '0;
      srow <= '0;
      lrow <= '0;
    end else if (accept) begin
      scol <= scol_next;
      lcol <= lcol_next;
      srow <= srow_next;
      lrow <= lrow_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_ACC;
      S_ACC:  state_next = last_q ? S_DIV : S_IDLE;
      S_DIV:  if (!status.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) last_q <= last_now;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.capture    = accept;
    cmd.write_back = (state == S_ACC);
    cmd.load_out   = (state == S_DIV) && !status.out_busy;
    cmd.col        = lcol;
    cmd.first      = (srow == '0) && (scol == '0);
    cmd.frame_last = (lcol == wm1) && (lrow == hm1);
    cmd.factor_m1  = fm1;
  end

endmodule

// ===== src/sbd_dpath.sv =====
// Datapath: column sum memory, per-channel accumulate, block mean and output register.
module sbd_dpath (
  input  logic                clk,
  input  logic                rst,
  input  sbd_pkg::sbd_cmd_t   cmd,
  output sbd_pkg::sbd_status_t status,
  input  sbd_pkg::pixel_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sbd_pkg::pixel_out_t out_data
);
  import sbd_pkg::*;

  logic [CHANNELS-1:0][SUM_W-1:0] sums_mem [MAX_LOGICAL_WIDTH];
  logic [CHANNELS-1:0][SUM_W-1:0] rd_data, acc_next, acc;
  logic [CHANNELS-1:0][7:0]       pix;
  logic [COL_W-1:0]               col_q;
  logic                           first_q, frame_last_q;

  // Hold the captured item and its position flags.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix          <= {in_data.red_in, in_data.green_in, in_data.blue_in, in_data.alpha_in};
      col_q        <= cmd.col;
      first_q      <= cmd.first;
      frame_last_q <= cmd.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) rd_data <= sums_mem[cmd.col];
    if (cmd.write_back) sums_mem[col_q] <= acc_next;
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      acc_next[c] = first_q ? SUM_W'(pix[c]) : rd_data[c] + SUM_W'(pix[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_back) acc <= acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.red_out    <= block_mean(acc[3], cmd.factor_m1);
      out_data.green_out  <= block_mean(acc[2], cmd.factor_m1);
      out_data.blue_out   <= block_mean(acc[1], cmd.factor_m1);
      out_data.alpha_out  <= block_mean(acc[0], cmd.factor_m1);
      out_data.frame_last <= frame_last_q;
    end
  end

  assign status.out_busy = out_valid && !out_ready;

endmodule

// ===== src/supersample_box_downscale_rgba8.sv =====
// Top level of the supersample box downscaler for RGBA8 pixel streams.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------
//  config   | cfg_we                | cfg_index (register), cfg_data (value)
//  input    | in_valid / in_ready   | in_data: one render-resolution pixel
//  output   | out_valid / out_ready | out_data: one logical pixel, frame_last
//
// An item is read from the single column sum memory at capture and written
// back in the next cycle (read-modify-write); the last sample of its block
// then passes the mean stage, which stalls while an earlier result waits.
// Reset returns all registers to 1 and the position counters to frame start;
// the column sum memory is not cleared, since a block's first sample
// overwrites its sums. A finished result waits in the output register while
// further items are taken; the next block mean stalls behind it, and no item is taken until it loads.
module supersample_box_downscale_rgba8 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sbd_pkg::pixel_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sbd_pkg::pixel_out_t           out_data
);
  import sbd_pkg::*;

  sbd_cmd_t    cmd;
  sbd_status_t status;

  // Sequence each item and walk the raster position.
  sbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Accumulate block sums and produce the rounded means.
  sbd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A captured item is written back in the very next cycle.
  a_capture_then_write: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> cmd.write_back)
    else $error("captured item not written back");

  // Never overwrite a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && !out_ready))
    else $error("output register overwritten while full");

  // A loaded mean shows up as a valid result.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  // No new item is taken while column sums are being written back.
  a_no_accept_in_write: assert property (@(posedge clk) disable iff (rst)
    cmd.write_back |-> !in_ready)
    else $error("input accepted during write-back");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the supersample box downscaler: pixel streams against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbd_pkg::*;

  // Index 3 decodes to no register; a write there must leave the frame position alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  localparam int RANDOM_PIXELS = 650;    // random render pixels to send
  localparam int DRAIN_CYCLES  = 8;      // lets the last item pass through the block
  localparam int CYCLE_LIMIT   = 400000; // several times the slowest legal run
  localparam int MAX_REPORTS   = 100;

  localparam int THROTTLE_SEND_LIGHT = 0; // sender idles 33%, receiver stalls 86%
  localparam int THROTTLE_SEND_HEAVY = 1; // the other way round
  localparam int THROTTLE_NONE       = 2;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  pixel_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  pixel_out_t out_data;

  supersample_box_downscale_rgba8 u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the registers, at their raw written widths (reset value 1).
  logic [DIM_W-1:0]    width_reg  = DIM_W'(1);
  logic [DIM_W-1:0]    height_reg = DIM_W'(1);
  logic [FACTOR_W-1:0] factor_reg = FACTOR_W'(1);

  // Predicted frame position and per-column channel sums.
  int unsigned col_pos  = 0;
  int unsigned samp_col = 0;
  int unsigned samp_row = 0;
  int unsigned row_pos  = 0;
  int unsigned block_sums [MAX_LOGICAL_WIDTH][CHANNELS];

  pixel_in_t  render_pixels[$];   // pixels waiting for the driver
  pixel_out_t expected_pixels[$]; // block means still to come out

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int pixels_sent       = 0;
  int pixels_checked    = 0;
  int results_predicted = 0;
  int frames_closed     = 0;
  int mismatches        = 0;
  int cycles            = 0;
  pixel_out_t next_expected;

  // Zero reads as one; anything above the maximum saturates.
  function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned hi);
    if (raw == 0) return 1;
    if (raw > hi) return hi;
    return raw;
  endfunction

  // Mirror a register write; every decoded write returns to the frame start.
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
    case (idx)
      CFG_LOGICAL_WIDTH:  width_reg  = data[DIM_W-1:0];
      CFG_LOGICAL_HEIGHT: height_reg = data[DIM_W-1:0];
      CFG_SCALE_FACTOR:   factor_reg = data[FACTOR_W-1:0];
      default: return;
    endcase
    col_pos  = 0;
    samp_col = 0;
    samp_row = 0;
    row_pos  = 0;
  endfunction

  // Accumulate one render pixel into its column and, on the block's last
  // sample, queue the rounded block mean.
  function automatic void resolve_pixel(input pixel_in_t px);
    int unsigned w, h, f, n, col;
    logic [7:0]  chan [CHANNELS];
    logic [7:0]  mean [CHANNELS];
    bit          first_samp, last_samp;
    pixel_out_t  res;
    w = clamp_dim(width_reg, MAX_LOGICAL_WIDTH);
    h = clamp_dim(height_reg, MAX_LOGICAL_HEIGHT);
    f = clamp_dim(factor_reg, MAX_FACTOR);
    n = f * f;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    if (samp_col >= f) samp_col = 0;
    if (samp_row >= f) samp_row = 0;
    chan[0] = px.red_in;
    chan[1] = px.green_in;
    chan[2] = px.blue_in;
    chan[3] = px.alpha_in;
    col = col_pos;
    first_samp = (samp_row == 0) && (samp_col == 0);
    last_samp  = (samp_row == f - 1) && (samp_col == f - 1);
    for (int c = 0; c < CHANNELS; c++) begin
      block_sums[col][c] = first_samp ? chan[c] : block_sums[col][c] + chan[c];
    end
    if (last_samp) begin
      for (int c = 0; c < CHANNELS; c++) begin
        mean[c] = 8'((block_sums[col][c] + n / 2) / n);
      end
      res.red_out    = mean[0];
      res.green_out  = mean[1];
      res.blue_out   = mean[2];
      res.alpha_out  = mean[3];
      res.frame_last = (col_pos == w - 1) && (row_pos == h - 1);
      expected_pixels.push_back(res);
      results_predicted++;
    end
    // Advance in render raster order: sample column, logical column, sample row, logical row.
    samp_col++;
    if (samp_col >= f) begin
      samp_col = 0;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        samp_row++;
        if (samp_row >= f) begin
          samp_row = 0;
          row_pos++;
          if (row_pos >= h) row_pos = 0;
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("[%0t] MISMATCH at logical pixel %0d: %s", $realtime, pixels_checked, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(input string field, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
  endtask

  // Driver: hold valid and payload until taken; start a new item only when the
  // channel is free, with a random gap in front of it. Register writes and
  // accepted pixels update the predictor at the edge where the block sees them.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (cfg_we) apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        resolve_pixel(in_data);
        pixels_sent++;
      end
      if (!in_valid || in_ready) begin
        if (render_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= render_pixels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare every taken item with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("logical pixel arrived with none expected");
        end else begin
          next_expected = expected_pixels.pop_front();
          check_field("red_out",    out_data.red_out,    next_expected.red_out);
          check_field("green_out",  out_data.green_out,  next_expected.green_out);
          check_field("blue_out",   out_data.blue_out,   next_expected.blue_out);
          check_field("alpha_out",  out_data.alpha_out,  next_expected.alpha_out);
          check_field("frame_last", out_data.frame_last, next_expected.frame_last);
          if (next_expected.frame_last) frames_closed++;
        end
        pixels_checked++;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles, %0d results outstanding",
               $realtime, cycles, expected_pixels.size());
      $display("supersample_box_downscale_rgba8 verification failed");
      $finish;
    end
  end

  function automatic pixel_in_t rgba(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic [7:0] a);
    pixel_in_t px;
    px.red_in   = r;
    px.green_in = g;
    px.blue_in  = b;
    px.alpha_in = a;
    return px;
  endfunction

  // Random pixel with the channel extremes weighted up.
  function automatic pixel_in_t rand_pixel();
    logic [31:0] bits;
    for (int c = 0; c < CHANNELS; c++) begin
      case ($urandom_range(0, 7))
        0:       bits[8*c +: 8] = 8'h00;
        1:       bits[8*c +: 8] = 8'hFF;
        default: bits[8*c +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return pixel_in_t'(bits);
  endfunction

  // Wait until the block has nothing pending, then let the last item finish.
  task automatic wait_idle();
    do @(negedge clk);
    while (render_pixels.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_throttle(input int mode);
    case (mode)
      THROTTLE_SEND_LIGHT: begin
        send_idle_pct  = 33;
        recv_stall_pct = 86;
      end
      THROTTLE_SEND_HEAVY: begin
        send_idle_pct  = 86;
        recv_stall_pct = 33;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  initial begin : stimulus
    int random_pixels;
    int phases;
    int count;
    int fe, we;
    logic [FACTOR_W-1:0] factor_raw;
    logic [DIM_W-1:0]    width_raw, height_raw;

    random_pixels = 0;
    phases        = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_throttle(THROTTLE_SEND_LIGHT);

    // Registers at reset (1 x 1, factor one): each pixel comes straight back
    // as the frame's only pixel.
    @(negedge clk);
    render_pixels.push_back(rgba(8'h00, 8'h00, 8'h00, 8'h00));
    render_pixels.push_back(rgba(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    render_pixels.push_back(rgba(8'h55, 8'hAA, 8'h0F, 8'hF0));
    wait_idle();

    // Factor two over two columns: send the top sample row, write the unused
    // index (must not restart), then the bottom row closes both blocks.
    cfg_write(CFG_SCALE_FACTOR, CFG_W'(2));
    cfg_write(CFG_LOGICAL_WIDTH, CFG_W'(2));
    cfg_write(CFG_LOGICAL_HEIGHT, CFG_W'(1));
    render_pixels.push_back(rgba(8'hFF, 8'h00, 8'h01, 8'h80));
    render_pixels.push_back(rgba(8'hFF, 8'h00, 8'h01, 8'h7F));
    render_pixels.push_back(rgba(8'hFF, 8'h00, 8'h01, 8'h00));
    render_pixels.push_back(rgba(8'hFF, 8'h00, 8'h00, 8'h00));
    wait_idle();
    cfg_write(CFG_SPARE_INDEX, CFG_W'(11'h7FF));
    render_pixels.push_back(rgba(8'hFF, 8'h00, 8'h00, 8'hFF));
    render_pixels.push_back(rgba(8'hFF, 8'h00, 8'h00, 8'h01));
    render_pixels.push_back(rgba(8'hFF, 8'h00, 8'h00, 8'h00));
    render_pixels.push_back(rgba(8'hFF, 8'h00, 8'h00, 8'h00));
    wait_idle();

    // Factor three, zero width and height (read as one). Abandon a block
    // half way with a rewrite, which restarts the frame, then send a full
    // block whose blue sum rounds up to one and alpha sum rounds down to zero.
    cfg_write(CFG_SCALE_FACTOR, CFG_W'(3));
    cfg_write(CFG_LOGICAL_WIDTH, CFG_W'(0));
    cfg_write(CFG_LOGICAL_HEIGHT, CFG_W'(0));
    for (int i = 0; i < 4; i++) render_pixels.push_back(rand_pixel());
    wait_idle();
    cfg_write(CFG_SCALE_FACTOR, CFG_W'(3));
    for (int i = 0; i < 9; i++) begin
      render_pixels.push_back(rgba(8'hFF, 8'(i * 28), 8'(i < 5), 8'(i < 4)));
    end

    // Random phases: new registers each time, most of them small enough to
    // close frames, a few at the saturating extremes. Throttling moves from
    // light sending to heavy sending to none across the thirds.
    while (random_pixels < RANDOM_PIXELS && phases < 400) begin
      wait_idle();
      if (random_pixels < RANDOM_PIXELS / 3) set_throttle(THROTTLE_SEND_LIGHT);
      else if (random_pixels < 2 * RANDOM_PIXELS / 3) set_throttle(THROTTLE_SEND_HEAVY);
      else set_throttle(THROTTLE_NONE);

      factor_raw = FACTOR_W'($urandom_range(0, 7));
      fe = clamp_dim(factor_raw, MAX_FACTOR);
      // Keep wide frames to factor one so results stay frequent.
      if (fe == 1 && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0:       width_raw = DIM_W'(1023);
          1:       width_raw = DIM_W'(1024);
          2:       width_raw = DIM_W'(2047);
          default: width_raw = DIM_W'($urandom_range(1025, 2047));
        endcase
      end else begin
        width_raw = DIM_W'($urandom_range(0, (fe >= 3) ? 4 : 12));
      end
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0:       height_raw = DIM_W'(0);
          1:       height_raw = DIM_W'(1024);
          2:       height_raw = DIM_W'(2047);
          default: height_raw = DIM_W'($urandom_range(0, 2047));
        endcase
      end else begin
        height_raw = DIM_W'($urandom_range(1, 4));
      end
      we = clamp_dim(width_raw, MAX_LOGICAL_WIDTH);

      cfg_write(CFG_SCALE_FACTOR, CFG_W'(factor_raw));
      cfg_write(CFG_LOGICAL_WIDTH, CFG_W'(width_raw));
      cfg_write(CFG_LOGICAL_HEIGHT, CFG_W'(height_raw));
      if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE_INDEX, CFG_W'($urandom_range(0, 2047)));

      count = fe * fe * we * $urandom_range(1, 3) + $urandom_range(0, 2 * fe * fe);
      if (count > 120) count = 120;
      if (count < 1) count = 1;
      for (int i = 0; i < count; i++) render_pixels.push_back(rand_pixel());
      random_pixels += count;
      phases++;
    end

    // Drain, then report.
    wait_idle();
    $display("Sent %0d render pixels over %0d random register settings plus directed cases;",
             pixels_sent, phases);
    $display("checked %0d logical pixels, %0d of them closing a frame, %0d mismatches.",
             pixels_checked, frames_closed, mismatches);
    if (mismatches == 0) begin
      $display("supersample_box_downscale_rgba8 verification clean");
    end else begin
      $display("supersample_box_downscale_rgba8 verification failed");
    end
    $finish;
  end

endmodule
